[rtl/core/arf_pkg.sv]
// Shared types and constants for the AR all-pole filter core.
// No dependencies; imported by every module of the block.
package arf_pkg;

  localparam int unsigned ARF_MAX_ORDER = 4;
  localparam int unsigned COEF_REGS     = 4;
  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned COEF_W        = 16;
  localparam int unsigned ORDER_W       = 3;
  localparam int unsigned COUNT_W       = 11;
  localparam int unsigned FRAC_SHIFT    = 14;
  localparam int unsigned ACC_W         = 51;
  localparam int unsigned PADDR_W       = 5;
  localparam int unsigned PDATA_W       = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [2:0] REG_ORDER   = 3'd0;
  localparam logic [2:0] REG_DISCARD = 3'd1;
  localparam logic [2:0] REG_COEF_0  = 3'd2;
  localparam logic [2:0] REG_COEF_1  = 3'd3;
  localparam logic [2:0] REG_COEF_2  = 3'd4;
  localparam logic [2:0] REG_COEF_3  = 3'd5;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] innovation;
    logic                       restart;
    logic                       last_sample;
  } arf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] series_value;
    logic                       last_out;
  } arf_out_t;

  typedef struct packed {
    logic [ORDER_W-1:0]                 order;
    logic [COUNT_W-1:0]                 discard_count;
    logic [COEF_REGS-1:0][COEF_W-1:0]   coef;
  } arf_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } arf_state_t;

endpackage

[rtl/core/arf_cfg.sv]
// APB-style configuration registers of the AR all-pole filter core.
// Depends on arf_pkg for register indexes and the config struct.
module arf_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [arf_pkg::PADDR_W-1:0]  paddr,
  input  logic [arf_pkg::PDATA_W-1:0]  pwdata,
  output logic [arf_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output arf_pkg::arf_cfg_t            cfg
);
  import arf_pkg::*;

  arf_cfg_t   cfg_r;
  arf_cfg_t   cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ORDER:   cfg_nxt.order         = pwdata[ORDER_W-1:0];
        REG_DISCARD: cfg_nxt.discard_count = pwdata[COUNT_W-1:0];
        REG_COEF_0:  cfg_nxt.coef[0]       = pwdata[COEF_W-1:0];
        REG_COEF_1:  cfg_nxt.coef[1]       = pwdata[COEF_W-1:0];
        REG_COEF_2:  cfg_nxt.coef[2]       = pwdata[COEF_W-1:0];
        REG_COEF_3:  cfg_nxt.coef[3]       = pwdata[COEF_W-1:0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORDER:   prdata = PDATA_W'(cfg_r.order);
      REG_DISCARD: prdata = PDATA_W'(cfg_r.discard_count);
      REG_COEF_0:  prdata = PDATA_W'($signed(cfg_r.coef[0]));
      REG_COEF_1:  prdata = PDATA_W'($signed(cfg_r.coef[1]));
      REG_COEF_2:  prdata = PDATA_W'($signed(cfg_r.coef[2]));
      REG_COEF_3:  prdata = PDATA_W'($signed(cfg_r.coef[3]));
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/core/arf_mac.sv]
// Shared multiply-accumulate unit with Q37.14 accumulator, rounding and saturation.
// Depends on arf_pkg for widths.
module arf_mac (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                en,
  input  logic signed [arf_pkg::SAMPLE_W-1:0] innovation,
  input  logic signed [arf_pkg::COEF_W-1:0]   coef,
  input  logic signed [arf_pkg::SAMPLE_W-1:0] sample,
  output logic signed [arf_pkg::SAMPLE_W-1:0] result
);
  import arf_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_W + COEF_W;
  localparam int unsigned SH_W   = ACC_W - FRAC_SHIFT;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;
  logic signed [SH_W-1:0]   max_val;
  logic signed [SH_W-1:0]   min_val;

  assign prod    = coef * sample;
  assign max_val = SH_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
  assign min_val = -max_val - SH_W'(1);

  always_comb begin
    acc_nxt = acc_r;
    if (load) begin
      acc_nxt = ACC_W'(innovation) <<< FRAC_SHIFT;
    end else if (en) begin
      acc_nxt = acc_r + ACC_W'(prod);
    end
  end

  always_comb begin
    rnd     = acc_r + (ACC_W'(1) <<< (FRAC_SHIFT - 1));
    shifted = SH_W'(rnd >>> FRAC_SHIFT);
    if (shifted > max_val) begin
      result = SAMPLE_W'(max_val);
    end else if (shifted < min_val) begin
      result = SAMPLE_W'(min_val);
    end else begin
      result = SAMPLE_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

[rtl/core/autoregressive_all_pole_filter_core.sv]
// Top level of the AR all-pole filter: sequencer, history, output register.
// Depends on arf_pkg, arf_cfg and arf_mac.
//
//   port group | direction | handshake          | payload
//   in_        | input     | in_valid/in_stall  | in_data   (arf_in_t)
//   out_       | output    | out_valid/out_stall| out_data  (arf_out_t)
//   cfg_       | input     | APB psel/penable   | paddr/pwdata/prdata
//
// A request is accepted in ST_IDLE, makes p passes through the shared MAC in
// ST_MAC, p being the active order (0 to 4) or 0 while the sample index is
// below p, then ST_FIN rounds, saturates and updates the history.
// Reset clears the sequencer, sample counter, output valid and registers.
// A stalled output holds the finishing step until the output register frees.
module autoregressive_all_pole_filter_core #(
  parameter int unsigned MAX_ORDER = arf_pkg::ARF_MAX_ORDER
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  arf_pkg::arf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output arf_pkg::arf_out_t                   out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [arf_pkg::PADDR_W-1:0]         cfg_paddr,
  input  logic [arf_pkg::PDATA_W-1:0]         cfg_pwdata,
  output logic [arf_pkg::PDATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import arf_pkg::*;

  localparam int unsigned HD    = (MAX_ORDER < COEF_REGS) ? MAX_ORDER : COEF_REGS;
  localparam int unsigned TAP_W = (HD > 1) ? $clog2(HD) : 1;
  localparam logic [ORDER_W-1:0] HD_ORD = ORDER_W'(HD);

  arf_cfg_t   cfg;
  arf_state_t state_r;
  arf_state_t state_nxt;

  logic [TAP_W-1:0]   tap_r;
  logic [TAP_W-1:0]   tap_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] idx;
  logic               emit_r;
  logic               last_r;

  logic signed [SAMPLE_W-1:0] hist_r [HD];
  logic signed [SAMPLE_W-1:0] mac_result;
  logic signed [COEF_W-1:0]   tap_coef;

  logic [ORDER_W-1:0] act_p;
  logic               accept;
  logic               tap_last;
  logic               slot_free;
  logic               fin_go;
  logic               mac_load;
  logic               mac_en;

  logic     out_valid_r;
  logic     out_valid_nxt;
  arf_out_t out_data_r;

  arf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign tap_coef = $signed(cfg.coef[2'(tap_r)]);

  arf_mac u_mac (
    .clk        (clk),
    .load       (mac_load),
    .en         (mac_en),
    .innovation (in_data.innovation),
    .coef       (tap_coef),
    .sample     (hist_r[tap_r]),
    .result     (mac_result)
  );

  assign act_p     = (cfg.order > HD_ORD) ? HD_ORD : cfg.order;
  assign accept    = in_valid & ~in_stall;
  assign idx       = in_data.restart ? '0 : count_r;
  assign tap_last  = (ORDER_W'(tap_r) + ORDER_W'(1)) == act_p;
  assign slot_free = ~out_valid_r | ~out_stall;
  assign fin_go    = (state_r == ST_FIN) & slot_free;
  assign count_nxt = (idx < COUNT_MAX) ? idx + COUNT_W'(1) : idx;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (act_p != '0 && idx >= COUNT_W'(act_p)) ? ST_MAC : ST_FIN;
        end
      end
      ST_MAC: begin
        if (tap_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    mac_load = 1'b0;
    mac_en   = 1'b0;
    tap_nxt  = tap_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        mac_load = in_valid;
        tap_nxt  = '0;
      end
      ST_MAC: begin
        mac_en  = 1'b1;
        tap_nxt = tap_r + TAP_W'(1);
      end
      ST_FIN: begin
        tap_nxt = '0;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (fin_go && emit_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      tap_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tap_r       <= tap_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit_r  <= idx >= cfg.discard_count;
      last_r  <= in_data.last_sample;
    end
    if (fin_go) begin
      hist_r[0] <= mac_result;
      for (int i = 1; i < HD; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
      if (emit_r) begin
        out_data_r.series_value <= mac_result;
        out_data_r.last_out     <= last_r;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
